// File: sv/tat_pkg.sv
package tat_pkg;

	// table and rule sizes
	localparam int ALERT_SLOTS = 16;
	localparam int RULE_SLOTS  = 8;
	localparam int NUM_REGS    = 8;

	localparam int SLOT_W = (ALERT_SLOTS > 1) ? $clog2(ALERT_SLOTS) : 1;
	localparam int RULE_W = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
	localparam int CNT_W  = $clog2(ALERT_SLOTS + 1);

	// register port
	localparam int REG_W   = 44;
	localparam int APB_DW  = 64;
	localparam int REG_IW  = $clog2(NUM_REGS);
	localparam int APB_AW  = REG_IW + 3;

	// stored entry fields
	localparam int INFO_W  = 25;
	localparam int VALUE_W = 32;

	// max resolve count
	localparam int RES_MAX = 31;

	typedef enum logic [1:0] {
		CMP_GT = 2'd0,
		CMP_LT = 2'd1,
		CMP_GE = 2'd2,
		CMP_LE = 2'd3
	} cmp_t;

	typedef enum logic [1:0] {
		OP_MEAS    = 2'd0,
		OP_RESOLVE = 2'd1,
		OP_READ    = 2'd2
	} op_t;

	typedef struct packed {
		logic        valid;
		logic [7:0]  stype;
		cmp_t        mode;
		logic        level;
		logic [31:0] thr;
	} rule_t;

	// controller to datapath
	typedef struct packed {
		logic              capture;
		logic              match_load;
		logic              rule_step;
		logic              resolve;
		logic              result_load;
		logic [RULE_W-1:0] rule_idx;
	} tat_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;
	} tat_sts_t;

endpackage

// File: sv/tat_cmd_if.sv
interface tat_cmd_if;
	logic               valid;
	logic               ready;
	logic [1:0]         op;
	logic [15:0]        sensor_num;
	logic [7:0]         sensor_kind;
	logic signed [31:0] sample_value;
	logic [3:0]         entry_index;

	modport source (output valid, op, sensor_num, sensor_kind, sample_value, entry_index,
		input ready);
	modport sink (input valid, op, sensor_num, sensor_kind, sample_value, entry_index,
		output ready);
endinterface

// File: sv/tat_rsp_if.sv
interface tat_rsp_if;
	logic               valid;
	logic               ready;
	logic [3:0]         new_alerts;
	logic [3:0]         dropped_alerts;
	logic [4:0]         clear_count;
	logic               entry_live;
	logic [15:0]        entry_sensor;
	logic [7:0]         entry_type;
	logic               entry_level;
	logic signed [31:0] entry_value;

	modport source (output valid, new_alerts, dropped_alerts, clear_count, entry_live,
		entry_sensor, entry_type, entry_level, entry_value, input ready);
	modport sink (input valid, new_alerts, dropped_alerts, clear_count, entry_live,
		entry_sensor, entry_type, entry_level, entry_value, output ready);
endinterface

// File: sv/tat_ram.sv
module tat_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// one write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: sv/tat_regs.sv
module tat_regs import tat_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output rule_t             rules [NUM_REGS]
);

	rule_t             rule_q [NUM_REGS];
	logic [REG_IW-1:0] sel;

	assign sel    = paddr[APB_AW-1:3];
	assign pready = 1'b1;

	// rule registers, written in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				rule_q[i] <= '0;
			end
		end else if (psel && penable && pwrite) begin
			rule_q[sel] <= rule_t'(pwdata[REG_W-1:0]);
		end
	end

	// read back
	assign prdata = APB_DW'(rule_q[sel]);

	always_comb begin
		for (int i = 0; i < NUM_REGS; i++) begin
			rules[i] = rule_q[i];
		end
	end

endmodule

// File: sv/tat_ctrl.sv
module tat_ctrl import tat_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	tat_cmd_if.sink  cmd,
	input  tat_sts_t sts,
	output tat_cmd_t ctl
);

	typedef enum logic [5:0] {
		ST_IDLE    = 6'b000001,
		ST_MATCH   = 6'b000010,
		ST_RULE    = 6'b000100,
		ST_RESOLVE = 6'b001000,
		ST_READ    = 6'b010000,
		ST_DONE    = 6'b100000
	} state_t;

	state_t            state_q, state_d;
	logic [RULE_W-1:0] rule_q;
	logic              last_rule;

	assign last_rule = (rule_q == RULE_W'(RULE_SLOTS - 1));
	assign cmd.ready = (state_q == ST_IDLE);

	// next state and commands
	always_comb begin
		state_d         = state_q;
		ctl             = '0;
		ctl.rule_idx    = rule_q;
		ctl.capture     = cmd.valid && (state_q == ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (cmd.valid) begin
					case (cmd.op)
						OP_MEAS:    state_d = ST_MATCH;
						OP_RESOLVE: state_d = ST_RESOLVE;
						OP_READ:    state_d = ST_READ;
						default:    state_d = ST_DONE;
					endcase
				end
			end
			ST_MATCH: begin
				ctl.match_load = 1'b1;
				state_d        = ST_RULE;
			end
			ST_RULE: begin
				ctl.rule_step = 1'b1;
				if (last_rule) begin
					state_d = ST_DONE;
				end
			end
			ST_RESOLVE: begin
				ctl.resolve = 1'b1;
				state_d     = ST_DONE;
			end
			ST_READ: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (sts.out_free) begin
					ctl.result_load = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state and rule counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rule_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_MATCH) begin
				rule_q <= '0;
			end else if (ctl.rule_step && !last_rule) begin
				rule_q <= rule_q + RULE_W'(1);
			end
		end
	end

endmodule

// File: sv/tat_dp.sv
module tat_dp import tat_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	tat_cmd_if.sink   cmd,
	tat_rsp_if.source rsp,
	input  rule_t     rules [NUM_REGS],
	input  tat_cmd_t  ctl,
	output tat_sts_t  sts
);

	typedef struct packed {
		logic [3:0]         new_alerts;
		logic [3:0]         dropped_alerts;
		logic [4:0]         clear_count;
		logic               entry_live;
		logic [15:0]        entry_sensor;
		logic [7:0]         entry_type;
		logic               entry_level;
		logic signed [31:0] entry_value;
	} result_t;

	// captured item
	logic [1:0]         op_q;
	logic [15:0]        sid_q;
	logic [7:0]         stype_q;
	logic signed [31:0] sval_q;
	logic [3:0]         idx_q;

	// per-rule match lanes
	logic [RULE_SLOTS-1:0] match_q;
	logic [RULE_SLOTS-1:0] lvl_q;

	// per-slot lanes
	logic [ALERT_SLOTS-1:0] live_q;
	logic [ALERT_SLOTS-1:0] used_q;
	logic [15:0]            tag_sid_q [ALERT_SLOTS];
	logic [ALERT_SLOTS-1:0] tag_lvl_q;

	logic [3:0]       fresh_q;
	logic [3:0]       drop_q;
	logic [4:0]       cleared_q;
	result_t          out_q;
	logic             out_valid_q;

	logic [ALERT_SLOTS-1:0] hit_vec;
	logic [ALERT_SLOTS-1:0] clr_vec;
	logic [SLOT_W-1:0]      hit_idx;
	logic [SLOT_W-1:0]      free_idx;
	logic                   hit_any;
	logic                   free_any;
	logic                   cur_match;
	logic                   cur_lvl;
	logic                   do_claim;
	logic                   do_refresh;
	logic [CNT_W-1:0]       clr_cnt;
	logic [4:0]             clr_sat;

	logic                 val_we;
	logic [SLOT_W-1:0]    val_waddr;
	logic [SLOT_W-1:0]    rd_addr;
	logic [INFO_W-1:0]    info_rdata;
	logic [VALUE_W-1:0]   val_rdata;
	logic                 rd_in_range;
	result_t              res_d;

	function automatic logic rule_fires(rule_t r, logic [7:0] t, logic signed [31:0] v);
		logic signed [31:0] thr;
		logic               ok;
		thr = signed'(r.thr);
		case (r.mode)
			CMP_GT:  ok = (v > thr);
			CMP_LT:  ok = (v < thr);
			CMP_GE:  ok = (v >= thr);
			CMP_LE:  ok = (v <= thr);
			default: ok = 1'b0;
		endcase
		return r.valid && (r.stype == t) && ok;
	endfunction

	assign cur_match = match_q[ctl.rule_idx];
	assign cur_lvl   = lvl_q[ctl.rule_idx];

	// slot lanes: refresh match, resolve match, free search
	always_comb begin
		hit_idx  = '0;
		free_idx = '0;
		for (int j = 0; j < ALERT_SLOTS; j++) begin
			hit_vec[j] = live_q[j] && (tag_sid_q[j] == sid_q) && (tag_lvl_q[j] == cur_lvl);
			clr_vec[j] = live_q[j] && (tag_sid_q[j] == sid_q);
		end
		for (int j = ALERT_SLOTS - 1; j >= 0; j--) begin
			if (hit_vec[j]) begin
				hit_idx = SLOT_W'(j);
			end
			if (!live_q[j]) begin
				free_idx = SLOT_W'(j);
			end
		end
	end

	assign hit_any    = |hit_vec;
	assign free_any   = ~&live_q;
	assign do_refresh = ctl.rule_step && cur_match && hit_any;
	assign do_claim   = ctl.rule_step && cur_match && !hit_any && free_any;
	assign val_we     = do_refresh || do_claim;
	assign val_waddr  = hit_any ? hit_idx : free_idx;

	assign clr_cnt = CNT_W'($countones(clr_vec));
	assign clr_sat = (32'(clr_cnt) > RES_MAX) ? 5'(RES_MAX) : 5'(clr_cnt);

	// entry storage: sensor, type, level in one memory, value in another
	assign rd_addr = SLOT_W'(idx_q);

	tat_ram #(
		.WIDTH (INFO_W),
		.DEPTH (ALERT_SLOTS)
	) u_info_ram (
		.clk   (clk),
		.we    (do_claim),
		.waddr (free_idx),
		.wdata ({sid_q, stype_q, cur_lvl}),
		.raddr (rd_addr),
		.rdata (info_rdata)
	);

	tat_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (ALERT_SLOTS)
	) u_value_ram (
		.clk   (clk),
		.we    (val_we),
		.waddr (val_waddr),
		.wdata (sval_q),
		.raddr (rd_addr),
		.rdata (val_rdata)
	);

	// result select
	assign rd_in_range = (32'(idx_q) < ALERT_SLOTS);

	always_comb begin
		res_d = '0;
		case (op_q)
			OP_MEAS: begin
				res_d.new_alerts     = fresh_q;
				res_d.dropped_alerts = drop_q;
			end
			OP_RESOLVE: begin
				res_d.clear_count = cleared_q;
			end
			OP_READ: begin
				if (rd_in_range && used_q[rd_addr]) begin
					res_d.entry_live   = live_q[rd_addr];
					res_d.entry_sensor = info_rdata[24:9];
					res_d.entry_type   = info_rdata[8:1];
					res_d.entry_level  = info_rdata[0];
					res_d.entry_value  = signed'(val_rdata);
				end
			end
			default: begin
				res_d = '0;
			end
		endcase
	end

	// item capture and rule lanes
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			op_q    <= cmd.op;
			sid_q   <= cmd.sensor_num;
			stype_q <= cmd.sensor_kind;
			sval_q  <= cmd.sample_value;
			idx_q   <= cmd.entry_index;
		end
		if (ctl.match_load) begin
			for (int i = 0; i < RULE_SLOTS; i++) begin
				match_q[i] <= rule_fires(rules[i], stype_q, sval_q);
				lvl_q[i]   <= rules[i].level;
			end
		end
		if (do_claim) begin
			tag_sid_q[free_idx] <= sid_q;
		end
		if (ctl.result_load) begin
			out_q <= res_d;
		end
	end

	// slot state, counters and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q      <= '0;
			used_q      <= '0;
			tag_lvl_q   <= '0;
			fresh_q     <= '0;
			drop_q      <= '0;
			cleared_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.capture) begin
				fresh_q   <= '0;
				drop_q    <= '0;
				cleared_q <= '0;
			end
			if (ctl.rule_step && cur_match && !hit_any) begin
				fresh_q <= fresh_q + 4'd1;
				if (!free_any) begin
					drop_q <= drop_q + 4'd1;
				end
			end
			if (do_claim) begin
				live_q[free_idx]    <= 1'b1;
				used_q[free_idx]    <= 1'b1;
				tag_lvl_q[free_idx] <= cur_lvl;
			end
			if (ctl.resolve) begin
				live_q    <= live_q & ~clr_vec;
				cleared_q <= clr_sat;
			end
			if (ctl.result_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.out_free = !out_valid_q || rsp.ready;

	assign rsp.valid          = out_valid_q;
	assign rsp.new_alerts     = out_q.new_alerts;
	assign rsp.dropped_alerts = out_q.dropped_alerts;
	assign rsp.clear_count    = out_q.clear_count;
	assign rsp.entry_live     = out_q.entry_live;
	assign rsp.entry_sensor   = out_q.entry_sensor;
	assign rsp.entry_type     = out_q.entry_type;
	assign rsp.entry_level    = out_q.entry_level;
	assign rsp.entry_value    = out_q.entry_value;

endmodule

// File: sv/threshold_alert_table.sv
// channel   dir  handshake      payload
// cmd       in   valid/ready    op, sensor_num, sensor_kind, sample_value, entry_index
// rsp       out  valid/ready    new_alerts, dropped_alerts, clear_count, entry_*
// apb       in   psel/penable   rule_a..rule_h at byte address 8*i, 64-bit data
//
// a measurement goes from accept through the match load and then the rule sequencer, one rule
// per cycle, with all table slots compared in parallel lanes
// resolve and read pass through a state of their own; one item is in work at a time
// arst_n clears the rules and marks every table slot free, no clearing pass
// a finished result waits in the output register, and the next item is taken meanwhile;
// the block stalls only when a second result is ready before the first is taken
module threshold_alert_table import tat_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	tat_cmd_if.sink           cmd,
	tat_rsp_if.source         rsp
);

	rule_t    rules [NUM_REGS];
	tat_cmd_t ctl;
	tat_sts_t sts;

	tat_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.rules   (rules)
	);

	tat_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sts    (sts),
		.ctl    (ctl)
	);

	tat_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.rsp    (rsp),
		.rules  (rules),
		.ctl    (ctl),
		.sts    (sts)
	);

	// one item in work at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.ready |=> !cmd.ready)
		else $error("item accepted while previous item in work");

	// never overwrite a result that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.result_load |-> (!rsp.valid || rsp.ready))
		else $error("result register overwritten");

	// controller issues one command at a time
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl.capture, ctl.match_load, ctl.rule_step, ctl.resolve, ctl.result_load}))
		else $error("overlapping datapath commands");

	// dropped alerts are a part of the new alerts
	a_drop_le_new: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.dropped_alerts <= rsp.new_alerts))
		else $error("dropped count exceeds new count");

endmodule

// File: sim/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import tat_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int IDLE_MAX      = 13;
	localparam int SETTLE_CYCLES = 20;
	localparam int PHASE_ITEMS   = 370;
	localparam int POOL_SIZE     = 12;
	localparam int HOLD_AT       = 150;
	localparam int HOLD_CYCLES   = 400;
	localparam int LIMIT_CYCLES  = 400000;
	localparam int MAX_SHOWN     = 40;

	typedef enum int {
		RULE_A, RULE_B, RULE_C, RULE_D, RULE_E, RULE_F, RULE_G, RULE_H
	} rule_reg_t;

	typedef struct {
		logic [1:0]  op;
		logic [15:0] sensor_num;
		logic [7:0]  sensor_kind;
		logic [31:0] sample_value;
		logic [3:0]  entry_index;
		bit          hold_for_drain;
	} cmd_item_t;

	typedef struct {
		logic [3:0]  new_alerts;
		logic [3:0]  dropped_alerts;
		logic [4:0]  clear_count;
		logic        entry_live;
		logic [15:0] entry_sensor;
		logic [7:0]  entry_type;
		logic        entry_level;
		logic [31:0] entry_value;
	} alert_reply_t;

	typedef struct packed {
		logic        live;
		logic [15:0] sensor;
		logic [7:0]  stype;
		logic        level;
		logic [31:0] value;
	} alert_slot_t;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	tat_cmd_if cmd_bus();
	tat_rsp_if rsp_bus();

	threshold_alert_table u_top (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cmd(cmd_bus),
		.rsp(rsp_bus)
	);

	// mirror of the rules and the alert table
	rule_t       rule_mirror[NUM_REGS];
	alert_slot_t alert_mirror[ALERT_SLOTS];

	cmd_item_t    cmd_backlog[$];
	alert_reply_t awaited_replies[$];

	int error_count = 0;
	int in_flight   = 0;
	int n_cmd       = 0;
	int n_sent      = 0;
	int n_taken     = 0;
	int send_gap    = 0;
	int recv_gap    = 0;
	int hold_left   = 0;
	bit hold_done   = 1'b0;
	int cycle_count = 0;

	task automatic report_error(input string msg);
		if (error_count < MAX_SHOWN)
			$display("ERROR at %0t: %s", $time, msg);
		error_count++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
		input logic [31:0] want);
		if (got !== want)
			report_error($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	// rule scan and table update for one item
	function automatic alert_reply_t predict_alert_reply(cmd_item_t it);
		alert_reply_t res;
		rule_t        r;
		logic         fires;
		logic         refreshed;
		int           free_slot;
		res = '{default: '0};
		case (it.op)
			OP_MEAS: begin
				for (int k = 0; k < RULE_SLOTS; k++) begin
					r = rule_mirror[k];
					if (!r.valid || r.stype != it.sensor_kind)
						continue;
					case (r.mode)
						CMP_GT: fires = $signed(it.sample_value) > $signed(r.thr);
						CMP_LT: fires = $signed(it.sample_value) < $signed(r.thr);
						CMP_GE: fires = $signed(it.sample_value) >= $signed(r.thr);
						default: fires = $signed(it.sample_value) <= $signed(r.thr);
					endcase
					if (!fires)
						continue;
					// refresh the live entry of this sensor and level
					refreshed = 1'b0;
					for (int j = 0; j < ALERT_SLOTS; j++) begin
						if (!refreshed && alert_mirror[j].live &&
							alert_mirror[j].sensor == it.sensor_num &&
							alert_mirror[j].level == r.level) begin
							alert_mirror[j].value = it.sample_value;
							refreshed = 1'b1;
						end
					end
					if (refreshed)
						continue;
					// otherwise claim the lowest slot that is not live
					res.new_alerts++;
					free_slot = -1;
					for (int j = 0; j < ALERT_SLOTS; j++) begin
						if (free_slot < 0 && !alert_mirror[j].live)
							free_slot = j;
					end
					if (free_slot < 0)
						res.dropped_alerts++;
					else
						alert_mirror[free_slot] = '{1'b1, it.sensor_num, it.sensor_kind,
							r.level, it.sample_value};
				end
			end
			OP_RESOLVE: begin
				for (int j = 0; j < ALERT_SLOTS; j++) begin
					if (alert_mirror[j].live && alert_mirror[j].sensor == it.sensor_num) begin
						alert_mirror[j].live = 1'b0;
						if (res.clear_count < RES_MAX)
							res.clear_count++;
					end
				end
			end
			OP_READ: begin
				if (it.entry_index < ALERT_SLOTS) begin
					res.entry_live   = alert_mirror[it.entry_index].live;
					res.entry_sensor = alert_mirror[it.entry_index].sensor;
					res.entry_type   = alert_mirror[it.entry_index].stype;
					res.entry_level  = alert_mirror[it.entry_index].level;
					res.entry_value  = alert_mirror[it.entry_index].value;
				end
			end
			default: begin
			end
		endcase
		return res;
	endfunction

	// apb write: setup then access cycle
	task automatic write_rule(input int idx, input rule_t val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_AW'(idx * 8);
		pwdata  <= APB_DW'(val);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		rule_mirror[idx] = val;
	endtask

	task automatic push_item(input logic [1:0] op, input logic [15:0] sid,
		input logic [7:0] stype, input logic [31:0] value, input logic [3:0] idx);
		cmd_item_t it;
		it = '{op, sid, stype, value, idx, 1'b0};
		cmd_backlog.push_back(it);
	endtask

	// block is idle once the backlog is sent and every reply is back
	task automatic wait_idle();
		do @(negedge clk); while (cmd_backlog.size() != 0 || cmd_bus.valid || in_flight != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// command driver
	always @(posedge clk) begin
		cmd_item_t cur;
		bit        taken;
		bit        offer;
		if (!arst_n) begin
			cmd_bus.valid <= 1'b0;
			send_gap = 0;
		end else begin
			taken = cmd_bus.valid && cmd_bus.ready;
			offer = cmd_bus.valid && !taken;
			if (taken) begin
				n_sent++;
				send_gap = ((n_sent / 80) % 4 == 2) ? 0 : $urandom_range(0, IDLE_MAX);
			end
			if (!offer) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (cmd_backlog.size() > 0 &&
					!(cmd_backlog[0].hold_for_drain && (taken || in_flight != 0))) begin
					cur = cmd_backlog.pop_front();
					offer = 1'b1;
					cmd_bus.op           <= cur.op;
					cmd_bus.sensor_num   <= cur.sensor_num;
					cmd_bus.sensor_kind  <= cur.sensor_kind;
					cmd_bus.sample_value <= cur.sample_value;
					cmd_bus.entry_index  <= cur.entry_index;
				end
			end
			cmd_bus.valid <= offer;
		end
	end

	// reply receiver with random stalls
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_bus.ready <= 1'b0;
			recv_gap = 0;
		end else begin
			if (rsp_bus.valid && rsp_bus.ready) begin
				n_taken++;
				recv_gap = ((n_taken / 100) % 3 == 1) ? 0 : $urandom_range(0, IDLE_MAX);
			end else if (recv_gap > 0) begin
				recv_gap--;
			end
			rsp_bus.ready <= (recv_gap == 0) && (hold_left == 0);
		end
	end

	// one long receiver hold-off so the block backs up
	always @(posedge clk) begin
		if (!arst_n) begin
			hold_left <= 0;
		end else if (n_cmd == HOLD_AT && !hold_done) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// monitor: predict on each accepted item, check each accepted reply
	always @(posedge clk) begin
		cmd_item_t    seen;
		alert_reply_t want;
		int           delta;
		if (arst_n) begin
			delta = 0;
			if (cmd_bus.valid && cmd_bus.ready) begin
				seen = '{cmd_bus.op, cmd_bus.sensor_num, cmd_bus.sensor_kind,
					cmd_bus.sample_value, cmd_bus.entry_index, 1'b0};
				awaited_replies.push_back(predict_alert_reply(seen));
				n_cmd <= n_cmd + 1;
				delta++;
			end
			if (rsp_bus.valid && rsp_bus.ready) begin
				if (awaited_replies.size() == 0) begin
					report_error("reply with no item waiting");
				end else begin
					want = awaited_replies.pop_front();
					check_field("new_alerts", 32'(rsp_bus.new_alerts),
						32'(want.new_alerts));
					check_field("dropped_alerts", 32'(rsp_bus.dropped_alerts),
						32'(want.dropped_alerts));
					check_field("clear_count", 32'(rsp_bus.clear_count),
						32'(want.clear_count));
					check_field("entry_live", 32'(rsp_bus.entry_live),
						32'(want.entry_live));
					check_field("entry_sensor", 32'(rsp_bus.entry_sensor),
						32'(want.entry_sensor));
					check_field("entry_type", 32'(rsp_bus.entry_type),
						32'(want.entry_type));
					check_field("entry_level", 32'(rsp_bus.entry_level),
						32'(want.entry_level));
					check_field("entry_value", 32'(rsp_bus.entry_value),
						32'(want.entry_value));
				end
				delta--;
			end
			in_flight <= in_flight + delta;
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// stimulus
	initial begin
		cmd_item_t   it;
		rule_t       phase_rules[NUM_REGS];
		rule_t       pick_rule;
		logic [7:0]  type_pool[3];
		logic [15:0] sensor_pool[POOL_SIZE];
		int          roll;

		arst_n  = 1'b0;
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = '0;
		pwdata  = '0;
		for (int k = 0; k < NUM_REGS; k++)
			rule_mirror[k] = '0;
		for (int j = 0; j < ALERT_SLOTS; j++)
			alert_mirror[j] = '0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		// directed rules: boundaries of every compare, an invalid rule, extreme types
		phase_rules[RULE_A] = '{1'b1, 8'h00, CMP_GT, 1'b0, 32'h0000_0000};
		phase_rules[RULE_B] = '{1'b1, 8'h00, CMP_GE, 1'b1, 32'h0001_0000};
		phase_rules[RULE_C] = '{1'b1, 8'hFF, CMP_LT, 1'b0, 32'h8000_0000};
		phase_rules[RULE_D] = '{1'b1, 8'hFF, CMP_LE, 1'b1, 32'h8000_0000};
		phase_rules[RULE_E] = '{1'b1, 8'h11, CMP_LE, 1'b0, 32'h7FFF_FFFF};
		phase_rules[RULE_F] = '{1'b0, 8'h11, CMP_GT, 1'b1, 32'h0000_0000};
		phase_rules[RULE_G] = '{1'b1, 8'h11, CMP_GT, 1'b1, 32'h7FFF_FFFF};
		phase_rules[RULE_H] = '{1'b1, 8'h00, CMP_LT, 1'b0, 32'hFFFF_0000};
		for (int k = 0; k < NUM_REGS; k++)
			write_rule(k, phase_rules[k]);
		@(negedge clk);

		// empty table, new alert, refresh plus second level, compare boundaries
		push_item(OP_READ, 16'h0000, 8'h00, 32'h0, 4'd0);
		push_item(OP_MEAS, 16'h0000, 8'h00, 32'h0000_0001, 4'd0);
		push_item(OP_MEAS, 16'h0000, 8'h00, 32'h0001_0000, 4'd0);
		push_item(OP_MEAS, 16'h0000, 8'h00, 32'h0000_0000, 4'd0);
		push_item(OP_MEAS, 16'hFFFF, 8'hFF, 32'h8000_0000, 4'd0);
		push_item(OP_MEAS, 16'hFFFF, 8'hFF, 32'h8000_0001, 4'd0);
		push_item(OP_MEAS, 16'h1234, 8'h11, 32'h7FFF_FFFF, 4'd0);
		// resolve sensor id 0 twice, then read the resolved slot
		push_item(OP_RESOLVE, 16'h0000, 8'h00, 32'h0, 4'd0);
		push_item(OP_RESOLVE, 16'h0000, 8'h00, 32'h0, 4'd0);
		push_item(OP_READ, 16'h0000, 8'h00, 32'h0, 4'd0);
		// unused op code leaves the table alone
		push_item(OP_UNUSED, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 4'd15);
		push_item(OP_MEAS, 16'h0005, 8'h00, 32'hFFFE_0000, 4'd0);
		// fill the table until alerts drop
		for (int k = 0; k < 8; k++)
			push_item(OP_MEAS, 16'h0100 + 16'(k), 8'h00, 32'h0002_0000, 4'd0);
		// resolved slots are claimed again with a full high-water mark
		push_item(OP_RESOLVE, 16'h0102, 8'h00, 32'h0, 4'd0);
		push_item(OP_MEAS, 16'h0200, 8'h00, 32'h7FFF_FFFF, 4'd0);
		push_item(OP_READ, 16'h0000, 8'h00, 32'h0, 4'd15);
		wait_idle();

		// random phases, each with its own rule set
		for (int p = 1; p <= 3; p++) begin
			for (int k = 0; k < 3; k++)
				type_pool[k] = 8'($urandom());
			for (int k = 0; k < POOL_SIZE; k++)
				sensor_pool[k] = 16'($urandom());
			if (p == 2) begin
				type_pool[0]   = 8'hFF;
				type_pool[1]   = 8'h00;
				sensor_pool[0] = 16'h0000;
				sensor_pool[1] = 16'hFFFF;
			end
			for (int k = 0; k < NUM_REGS; k++) begin
				if (p == 3) begin
					phase_rules[k] = rule_t'(44'({$urandom(), $urandom()}));
				end else begin
					phase_rules[k].valid = ($urandom_range(0, 7) != 0);
					phase_rules[k].stype = type_pool[$urandom_range(0, 2)];
					phase_rules[k].mode  = cmp_t'($urandom_range(0, 3));
					phase_rules[k].level = 1'($urandom_range(0, 1));
					phase_rules[k].thr   = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
				end
			end
			// all-ones and all-zero rule words
			if (p == 2) begin
				phase_rules[RULE_A] = '1;
				phase_rules[RULE_B] = '0;
			end
			for (int k = 0; k < NUM_REGS; k++)
				write_rule(k, phase_rules[k]);
			@(negedge clk);

			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// mostly measurements from a small sensor pool that hit the rules
				pick_rule = phase_rules[$urandom_range(0, NUM_REGS - 1)];
				it.op          = OP_MEAS;
				it.sensor_num  = sensor_pool[$urandom_range(0, POOL_SIZE - 1)];
				it.sensor_kind = pick_rule.stype;
				case ($urandom_range(0, 4))
					0: it.sample_value = pick_rule.thr;
					1, 2: it.sample_value = pick_rule.thr + $urandom_range(0, 8) - 4;
					3: it.sample_value = $urandom();
					default: it.sample_value = $urandom_range(0, 1) ? 32'h7FFF_FFFF
						: 32'h8000_0000;
				endcase
				it.entry_index    = 4'($urandom_range(0, 15));
				it.hold_for_drain = (i % 150 == 75);
				roll = $urandom_range(0, 99);
				if (roll < 10) begin
					it.op = OP_RESOLVE;
				end else if (roll < 22) begin
					it.op = OP_READ;
				end else if (roll < 30) begin
					// noise: any field value, unused op included
					it.op           = 2'($urandom());
					it.sensor_num   = 16'($urandom());
					it.sensor_kind  = 8'($urandom());
					it.sample_value = $urandom();
				end
				cmd_backlog.push_back(it);
			end
			wait_idle();
		end

		if (awaited_replies.size() != 0)
			report_error($sformatf("%0d replies never arrived", awaited_replies.size()));
		if (error_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
